### design/sm3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_pkg
// shared types, constants and helper functions of the sm3 hash engine
// ----------------------------------------------------------------------------
package sm3_pkg;

	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h7a879d8a;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// block word that holds the high half of the length
	localparam logic [3:0] LEN_HI_POS = 4'd14;
	localparam logic [3:0] LAST_POS   = 4'd15;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [5:0] FF_SWITCH  = 6'd16;
	localparam logic [2:0] LAST_INDEX = 3'd7;
	localparam logic [2:0] MAX_BYTES  = 3'd4;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t word;
		logic  fin;
	} blk_word_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_PAD,
		F_ZERO,
		F_LEN_HI,
		F_LEN_LO
	} front_state_t;

	typedef enum logic [1:0] {
		B_LOAD,
		B_ROUND,
		B_UPDATE,
		B_OUT
	} back_state_t;

	function automatic word_t iv_word(input logic [2:0] i);
		word_t v;
		unique case (i)
			3'd0: v = 32'h7380166f;
			3'd1: v = 32'h4914b2b9;
			3'd2: v = 32'h172442d7;
			3'd3: v = 32'hda8a0600;
			3'd4: v = 32'ha96f30bc;
			3'd5: v = 32'h163138aa;
			3'd6: v = 32'he38dee4d;
			default: v = 32'hb0fb0e4e;
		endcase
		return v;
	endfunction

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		word_t r;
		r = (x << n) | (x >> (6'd32 - {1'b0, n}));
		return r;
	endfunction

	function automatic word_t perm0(input word_t x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic word_t perm1(input word_t x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	// round constant already rotated by the round number
	function automatic word_t t_rot(input logic [5:0] j);
		word_t t;
		t = (j < FF_SWITCH) ? T_LOW : T_HIGH;
		return rotl(t, j[4:0]);
	endfunction

endpackage
`default_nettype wire

### design/sm3_hash_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_hash_engine_core
// sm3 hash of a byte message delivered as big-endian words
// ----------------------------------------------------------------------------
// each item carries up to four message bytes (valid_bytes from the top of
// data_word, counts above four taken as four); last_word closes the message
// and appends the sm3 padding. a packer takes one item per cycle while the
// word queue has room and no padding is being written. at the end of a
// message it writes the padding word, the zero words up to the length
// position and the two length words, stalling whenever the queue is full.
// the compression engine gathers a 512-bit block of 16 words, runs the 64
// rounds (one round per cycle) and folds the result into the chaining
// value; the round unit limits the throughput.
// eight digest items follow the final block,
// index 0 first, digest_last on index 7, after which the next message starts
// from the standard initial value. the packer runs ahead of the engine
// through a four-entry queue, so the next message can be taken while the
// digest waits
// ----------------------------------------------------------------------------
module sm3_hash_engine_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  valid_bytes,
	input  wire logic        last_word,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             digest_last
);

	// packer to queue
	logic               wr_en;
	sm3_pkg::blk_word_t wr_data;
	logic               q_full;
	// queue to engine
	logic               rd_en;
	sm3_pkg::blk_word_t rd_data;
	logic               q_empty;

	sm3_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last_word   (last_word),
		.q_full      (q_full),
		.q_push      (wr_en),
		.q_data      (wr_data)
	);

	sm3_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.q_full  (q_full),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.q_empty (q_empty)
	);

	// engine pops a word whenever it is gathering a block and the queue is not empty
	sm3_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (rd_data),
		.q_pop       (rd_en),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.digest_last (digest_last)
	);

endmodule
`default_nettype wire

### design/sm3_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_front
// packs message bytes into block words, counts bits and appends the padding
// ----------------------------------------------------------------------------
module sm3_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [31:0]       data_word,
	input  wire logic [2:0]        valid_bytes,
	input  wire logic              last_word,
	input  wire logic              q_full,
	output logic                   q_push,
	output sm3_pkg::blk_word_t     q_data
);

	sm3_pkg::front_state_t state_q, state_d;
	logic [63:0] bit_len_q;
	logic [3:0]  bwc_q;
	logic [31:0] pw_q;
	logic [1:0]  pb_q;

	logic        accept;
	logic [2:0]  cnt;
	logic [2:0]  total;
	logic [1:0]  rem;
	logic [63:0] cat;
	logic [31:0] full_word;
	logic [31:0] left_word;
	logic [31:0] pad_word;
	logic [3:0]  bwc_inc;

	assign full   = (state_q != sm3_pkg::F_IDLE) || q_full;
	assign accept = push && !full;

	always_comb begin
		cnt       = (valid_bytes > sm3_pkg::MAX_BYTES) ? sm3_pkg::MAX_BYTES : valid_bytes;
		total     = {1'b0, pb_q} + cnt;
		rem       = total[1:0];
		cat       = ({32'b0, pw_q} << {cnt, 3'b0})
			| ({32'b0, data_word} >> (6'd32 - {cnt, 3'b0}));
		full_word = 32'(cat >> {rem, 3'b0});
		left_word = cat[31:0] & ~(32'hffffffff << {rem, 3'b0});
		pad_word  = (pw_q << (6'd32 - {pb_q, 3'b0}))
			| (32'h80 << {2'd3 - pb_q, 3'b0});
		bwc_inc   = bwc_q + 4'd1;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sm3_pkg::F_IDLE:
				if (accept && last_word) state_d = sm3_pkg::F_PAD;
			sm3_pkg::F_PAD:
				if (!q_full) state_d = (bwc_inc == sm3_pkg::LEN_HI_POS)
					? sm3_pkg::F_LEN_HI : sm3_pkg::F_ZERO;
			sm3_pkg::F_ZERO:
				if (!q_full && bwc_inc == sm3_pkg::LEN_HI_POS) state_d = sm3_pkg::F_LEN_HI;
			sm3_pkg::F_LEN_HI:
				if (!q_full) state_d = sm3_pkg::F_LEN_LO;
			sm3_pkg::F_LEN_LO:
				if (!q_full) state_d = sm3_pkg::F_IDLE;
			default: state_d = sm3_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		q_push      = 1'b0;
		q_data.word = full_word;
		q_data.fin  = 1'b0;
		unique case (state_q)
			sm3_pkg::F_IDLE: begin
				q_push = accept && (total >= sm3_pkg::MAX_BYTES);
			end
			sm3_pkg::F_PAD: begin
				q_push      = !q_full;
				q_data.word = pad_word;
			end
			sm3_pkg::F_ZERO: begin
				q_push      = !q_full;
				q_data.word = '0;
			end
			sm3_pkg::F_LEN_HI: begin
				q_push      = !q_full;
				q_data.word = bit_len_q[63:32];
			end
			sm3_pkg::F_LEN_LO: begin
				q_push      = !q_full;
				q_data.word = bit_len_q[31:0];
				q_data.fin  = 1'b1;
			end
			default: q_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sm3_pkg::F_IDLE;
			bit_len_q <= '0;
			bwc_q     <= '0;
			pw_q      <= '0;
			pb_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sm3_pkg::F_IDLE) begin
				if (accept) begin
					bit_len_q <= bit_len_q + {58'b0, cnt, 3'b0};
					if (total >= sm3_pkg::MAX_BYTES) begin
						pw_q  <= left_word;
						pb_q  <= rem;
						bwc_q <= bwc_inc;
					end else begin
						pw_q <= cat[31:0];
						pb_q <= total[1:0];
					end
				end
			end else if (q_push) begin
				if (state_q == sm3_pkg::F_LEN_LO) begin
					bit_len_q <= '0;
					bwc_q     <= '0;
					pw_q      <= '0;
					pb_q      <= '0;
				end else begin
					bwc_q <= bwc_inc;
				end
			end
		end
	end

endmodule
`default_nettype wire

### design/sm3_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_queue
// short word queue between the byte packer and the compression engine
// ----------------------------------------------------------------------------
module sm3_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire sm3_pkg::blk_word_t wr_data,
	output logic                    q_full,
	input  wire logic               rd_en,
	output sm3_pkg::blk_word_t      rd_data,
	output logic                    q_empty
);

	sm3_pkg::blk_word_t mem_q [sm3_pkg::QUEUE_DEPTH];
	logic [sm3_pkg::QUEUE_AW-1:0] wp_q, rp_q;
	logic [sm3_pkg::QUEUE_AW:0]   cnt_q;

	assign q_full  = (cnt_q == (sm3_pkg::QUEUE_AW+1)'(sm3_pkg::QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en && !q_full) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !q_full) wp_q <= wp_q + 1'b1;
			if (rd_en && !q_empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{sm3_pkg::QUEUE_AW{1'b0}}, wr_en && !q_full}
				- {{sm3_pkg::QUEUE_AW{1'b0}}, rd_en && !q_empty};
		end
	end

endmodule
`default_nettype wire

### design/sm3_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_back
// gathers block words, runs the 64 compression rounds and emits the digest
// ----------------------------------------------------------------------------
module sm3_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire sm3_pkg::blk_word_t q_data,
	output logic                    q_pop,
	output logic                    empty,
	input  wire logic               pop,
	output logic [31:0]             digest_word,
	output logic [2:0]              word_index,
	output logic                    digest_last
);

	sm3_pkg::back_state_t state_q, state_d;
	sm3_pkg::word_t win_q [16];
	sm3_pkg::word_t cv_q  [8];
	sm3_pkg::word_t r_q   [8];
	logic [3:0] ld_q;
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       fin_q;

	sm3_pkg::word_t w_new, a12, ss1, ss2, ff, gg, tt1, tt2, shift_in;
	logic shift_en;
	logic out_take;

	assign q_pop       = (state_q == sm3_pkg::B_LOAD) && !q_empty;
	assign empty       = (state_q != sm3_pkg::B_OUT);
	assign out_take    = pop && !empty;
	assign digest_word = cv_q[idx_q];
	assign word_index  = idx_q;
	assign digest_last = (idx_q == sm3_pkg::LAST_INDEX);

	always_comb begin
		w_new = sm3_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3_pkg::rotl(win_q[13], 5'd15))
			^ sm3_pkg::rotl(win_q[3], 5'd7) ^ win_q[10];
		a12 = sm3_pkg::rotl(r_q[0], 5'd12);
		ss1 = sm3_pkg::rotl(a12 + r_q[4] + sm3_pkg::t_rot(rnd_q), 5'd7);
		ss2 = ss1 ^ a12;
		if (rnd_q < sm3_pkg::FF_SWITCH) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ff + r_q[3] + ss2 + (win_q[0] ^ win_q[4]);
		tt2 = gg + r_q[7] + ss1 + win_q[0];
		shift_en = q_pop || (state_q == sm3_pkg::B_ROUND);
		shift_in = (state_q == sm3_pkg::B_ROUND) ? w_new : q_data.word;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sm3_pkg::B_LOAD:
				if (q_pop && ld_q == sm3_pkg::LAST_POS) state_d = sm3_pkg::B_ROUND;
			sm3_pkg::B_ROUND:
				if (rnd_q == sm3_pkg::LAST_ROUND) state_d = sm3_pkg::B_UPDATE;
			sm3_pkg::B_UPDATE:
				state_d = fin_q ? sm3_pkg::B_OUT : sm3_pkg::B_LOAD;
			sm3_pkg::B_OUT:
				if (out_take && idx_q == sm3_pkg::LAST_INDEX) state_d = sm3_pkg::B_LOAD;
			default: state_d = sm3_pkg::B_LOAD;
		endcase
	end

	// message window and working registers carry no reset
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= shift_in;
		end
		if (q_pop && ld_q == sm3_pkg::LAST_POS) begin
			for (int i = 0; i < 8; i++) r_q[i] <= cv_q[i];
		end else if (state_q == sm3_pkg::B_ROUND) begin
			r_q[3] <= r_q[2];
			r_q[2] <= sm3_pkg::rotl(r_q[1], 5'd9);
			r_q[1] <= r_q[0];
			r_q[0] <= tt1;
			r_q[7] <= r_q[6];
			r_q[6] <= sm3_pkg::rotl(r_q[5], 5'd19);
			r_q[5] <= r_q[4];
			r_q[4] <= sm3_pkg::perm0(tt2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sm3_pkg::B_LOAD;
			ld_q    <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			fin_q   <= 1'b0;
			for (int i = 0; i < 8; i++) cv_q[i] <= sm3_pkg::iv_word(3'(i));
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				ld_q <= ld_q + 4'd1;
				if (ld_q == sm3_pkg::LAST_POS) fin_q <= q_data.fin;
			end
			if (state_q == sm3_pkg::B_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == sm3_pkg::B_UPDATE) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ r_q[i];
				idx_q <= '0;
			end
			if (out_take) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == sm3_pkg::LAST_INDEX) begin
					for (int i = 0; i < 8; i++) cv_q[i] <= sm3_pkg::iv_word(3'(i));
				end
			end
		end
	end

endmodule
`default_nettype wire
